[src/lzbd_pkg.sv]
// shared types and constants for the lz77 byte decompressor
`timescale 1ns / 1ps
package lzbd_pkg;

	localparam int WIN_BYTES = 4096;
	localparam int WIN_AW    = $clog2(WIN_BYTES);
	localparam int SIZE_BITS = 24;
	localparam int LEN_W     = 5;
	localparam int MADE_W    = WIN_AW + 1;

	localparam logic [7:0]       TYPE_BYTE = 8'h10;
	localparam logic [LEN_W-1:0] MATCH_MIN = LEN_W'(3);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_start;
	} cmp_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       status;
		logic       run_last;
		logic       stream_end;
	} dec_word_t;

endpackage

[src/lz77_byte_decompressor_core.sv]
// lz77 (type 0x10) byte decompressor top level
//  channel  dir  handshake             word
//  cmp      in   cmp_valid/cmp_stall   cmp_word: in_byte, stream_start
//  dec      out  dec_valid/dec_stall   dec_word: out_byte, status, run_last, stream_end
// header, flag and literal bytes are taken whenever input is not stalled; a literal byte needs the output free
// a match copy gives one byte a cycle from the history memory while the output is free, the first read
//   when its second byte is taken; input stalls until all copied bytes are out (at most 18)
// arst_n clears all control state; history contents are undefined until written
// a stalled output holds its word and stalls input while it waits
`timescale 1ns / 1ps
module lz77_byte_decompressor_core
	import lzbd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmp_valid,
	output logic      cmp_stall,
	input  cmp_word_t cmp_word,
	output logic      dec_valid,
	input  logic      dec_stall,
	output dec_word_t dec_word
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SIZE0  = 3'd1;
	localparam logic [2:0] PH_SIZE1  = 3'd2;
	localparam logic [2:0] PH_SIZE2  = 3'd3;
	localparam logic [2:0] PH_FLAGS  = 3'd4;
	localparam logic [2:0] PH_TOKEN  = 3'd5;
	localparam logic [2:0] PH_MATCH2 = 3'd6;

	logic [2:0]           phase_q;
	logic [SIZE_BITS-1:0] bytes_left_q;
	logic [MADE_W-1:0]    made_q;
	logic [7:0]           flag_q;
	logic [2:0]           tok_q;
	logic [7:0]           mfirst_q;
	logic [WIN_AW-1:0]    wp_q;
	logic [7:0]           last_q;
	logic [MADE_W-1:0]    dist_q;
	logic [WIN_AW-1:0]    rd_ptr_q;
	logic [LEN_W-1:0]     rd_left_q;
	logic [LEN_W-1:0]     emit_left_q;
	logic                 rd_pend_q;
	logic                 out_valid_q;
	dec_word_t            out_q;

	logic                 acc, busy, out_free, tok_is_match;
	logic                 lit_emit, cp_emit, emit, err, start_copy, cp_ok, fin_zero;
	logic [LEN_W-1:0]     match_len, cnt;
	logic [MADE_W-1:0]    match_dist;
	logic [7:0]           cp_byte, emit_byte, rdata;
	logic                 re;
	logic [WIN_AW-1:0]    raddr;
	logic [SIZE_BITS-1:0] size_full;

	assign out_free  = !out_valid_q || !dec_stall;
	assign busy      = rd_pend_q || (emit_left_q != '0);
	assign cmp_stall = busy || (out_valid_q && dec_stall);
	assign acc       = cmp_valid && !cmp_stall;

	assign match_len    = {1'b0, mfirst_q[7:4]} + MATCH_MIN;
	assign match_dist   = {1'b0, mfirst_q[3:0], cmp_word.in_byte} + MADE_W'(1);
	assign fin_zero     = bytes_left_q <= SIZE_BITS'(match_len);
	assign cnt          = fin_zero ? bytes_left_q[LEN_W-1:0] : match_len;
	assign tok_is_match = flag_q[3'd7 - tok_q];
	assign size_full    = {cmp_word.in_byte, bytes_left_q[15:0]};

	assign err        = acc && cmp_word.stream_start && (cmp_word.in_byte != TYPE_BYTE);
	assign lit_emit   = acc && !cmp_word.stream_start && (phase_q == PH_TOKEN) && !tok_is_match;
	assign start_copy = acc && !cmp_word.stream_start && (phase_q == PH_MATCH2);
	assign cp_emit    = rd_pend_q && out_free;
	assign emit       = lit_emit || cp_emit;

	assign cp_ok     = dist_q <= made_q;
	assign cp_byte   = !cp_ok ? 8'h00 : ((dist_q == MADE_W'(1)) ? last_q : rdata);
	assign emit_byte = cp_emit ? cp_byte : cmp_word.in_byte;

	assign re    = start_copy || ((rd_left_q != '0) && (!rd_pend_q || cp_emit));
	assign raddr = start_copy ? (wp_q - match_dist[WIN_AW-1:0]) : rd_ptr_q;

	lzbd_hist_ram u_hist (
		.clk   (clk),
		.we    (emit),
		.waddr (wp_q),
		.wdata (emit_byte),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// copy engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q   <= 1'b0;
			rd_left_q   <= '0;
			emit_left_q <= '0;
			rd_ptr_q    <= '0;
			dist_q      <= '0;
		end else begin
			if (re) begin
				rd_pend_q <= 1'b1;
			end else if (cp_emit) begin
				rd_pend_q <= 1'b0;
			end
			if (start_copy) begin
				rd_left_q   <= cnt - LEN_W'(1);
				emit_left_q <= cnt;
				rd_ptr_q    <= wp_q - match_dist[WIN_AW-1:0] + WIN_AW'(1);
				dist_q      <= match_dist;
			end else begin
				if (re) begin
					rd_left_q <= rd_left_q - LEN_W'(1);
					rd_ptr_q  <= rd_ptr_q + WIN_AW'(1);
				end
				if (cp_emit) begin
					emit_left_q <= emit_left_q - LEN_W'(1);
				end
			end
		end
	end

	// stream parser and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bytes_left_q <= '0;
			made_q       <= '0;
			flag_q       <= '0;
			tok_q        <= '0;
			mfirst_q     <= '0;
			wp_q         <= '0;
			last_q       <= '0;
		end else begin
			if (emit) begin
				wp_q         <= wp_q + WIN_AW'(1);
				last_q       <= emit_byte;
				bytes_left_q <= bytes_left_q - SIZE_BITS'(1);
				if (made_q < MADE_W'(WIN_BYTES)) begin
					made_q <= made_q + MADE_W'(1);
				end
			end
			if (acc) begin
				if (cmp_word.stream_start) begin
					if (err) begin
						phase_q <= PH_IDLE;
					end else begin
						phase_q      <= PH_SIZE0;
						bytes_left_q <= '0;
						made_q       <= '0;
						wp_q         <= '0;
						flag_q       <= '0;
						tok_q        <= '0;
						mfirst_q     <= '0;
					end
				end else begin
					case (phase_q)
						PH_SIZE0: begin
							bytes_left_q <= SIZE_BITS'(cmp_word.in_byte);
							phase_q      <= PH_SIZE1;
						end
						PH_SIZE1: begin
							bytes_left_q[15:8] <= cmp_word.in_byte;
							phase_q            <= PH_SIZE2;
						end
						PH_SIZE2: begin
							bytes_left_q <= size_full;
							phase_q      <= (size_full == '0) ? PH_IDLE : PH_FLAGS;
						end
						PH_FLAGS: begin
							flag_q  <= cmp_word.in_byte;
							tok_q   <= '0;
							phase_q <= PH_TOKEN;
						end
						PH_TOKEN: begin
							if (tok_is_match) begin
								mfirst_q <= cmp_word.in_byte;
								phase_q  <= PH_MATCH2;
							end else begin
								tok_q <= tok_q + 3'd1;
								if (bytes_left_q == SIZE_BITS'(1)) begin
									phase_q <= PH_IDLE;
								end else begin
									phase_q <= (tok_q == 3'd7) ? PH_FLAGS : PH_TOKEN;
								end
							end
						end
						PH_MATCH2: begin
							tok_q <= tok_q + 3'd1;
							if (fin_zero) begin
								phase_q <= PH_IDLE;
							end else begin
								phase_q <= (tok_q == 3'd7) ? PH_FLAGS : PH_TOKEN;
							end
						end
						default: begin
							phase_q <= PH_IDLE;
						end
					endcase
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit || err) begin
			out_valid_q <= 1'b1;
		end else if (out_free) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (err) begin
			out_q.out_byte   <= 8'h00;
			out_q.status     <= 1'b1;
			out_q.run_last   <= 1'b1;
			out_q.stream_end <= 1'b0;
		end else if (emit) begin
			out_q.out_byte   <= emit_byte;
			out_q.status     <= 1'b0;
			out_q.run_last   <= cp_emit ? (emit_left_q == LEN_W'(1)) : 1'b1;
			out_q.stream_end <= bytes_left_q == SIZE_BITS'(1);
		end
	end

	assign dec_valid = out_valid_q;
	assign dec_word  = out_q;

endmodule

[src/lzbd_hist_ram.sv]
// history window memory, one write port and one registered read port
`timescale 1ns / 1ps
module lzbd_hist_ram
	import lzbd_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [WIN_AW-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [WIN_AW-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem_q [WIN_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/lzbd_checker.sv]
// port checks for the lz77 byte decompressor, bound to the top level
`timescale 1ns / 1ps
module lzbd_checker
	import lzbd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      cmp_valid,
	input logic      cmp_stall,
	input cmp_word_t cmp_word,
	input logic      dec_valid,
	input logic      dec_stall,
	input dec_word_t dec_word
);

	// a stalled output word holds
	a_dec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |=> dec_valid && $stable(dec_word))
		else $error("stalled output word changed");

	// no input taken while a result waits
	a_back_stall: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_stall |-> cmp_stall)
		else $error("input not stalled behind a waiting result");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_word.status |->
			dec_word.run_last && !dec_word.stream_end && (dec_word.out_byte == 8'h00))
		else $error("malformed error word");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && dec_word.stream_end |-> dec_word.run_last && !dec_word.status)
		else $error("stream end not on the last word of a run");

endmodule

bind lz77_byte_decompressor_core lzbd_checker u_lzbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmp_valid (cmp_valid),
	.cmp_stall (cmp_stall),
	.cmp_word  (cmp_word),
	.dec_valid (dec_valid),
	.dec_stall (dec_stall),
	.dec_word  (dec_word)
);

[bench/tb_lz77_byte_decompressor_core.sv]
// testbench for the lz77 byte decompressor core: compressed streams checked word by word
`timescale 1ns / 1ps
module tb_lz77_byte_decompressor_core;
	import lzbd_pkg::*;

	localparam int IDLE_LIMIT  = 3000;
	localparam int LONG_HOLD   = 300;
	localparam int RANDOM_WORDS = 220;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SIZE_LO, ST_SIZE_MID, ST_SIZE_HI, ST_FLAGS, ST_TOKEN, ST_MATCH_LO
	} dec_phase_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmp_valid;
	logic      cmp_stall;
	cmp_word_t cmp_word;
	logic      dec_valid;
	logic      dec_stall;
	dec_word_t dec_word;

	// local decoder state
	dec_phase_t      cur_phase = ST_IDLE;
	logic [23:0]     left_cnt  = '0;
	logic [12:0]     made_cnt  = '0;
	logic [7:0]      flag_reg  = '0;
	logic [2:0]      tok_idx   = '0;
	logic [7:0]      match_hi  = '0;
	logic [11:0]     wr_ptr    = '0;
	logic [7:0]      hist_mem [0:WIN_BYTES-1];
	dec_word_t       dec_expected [$];

	int fail_count   = 0;
	int useful_words = 0;
	int in_words     = 0;
	int out_words    = 0;
	int stream_count = 0;
	int idle_cycles  = 0;
	int hold_req     = 0;
	int hold_done    = 0;
	bit tx_eager     = 1'b0;
	bit rx_eager     = 1'b0;

	lz77_byte_decompressor_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmp_valid (cmp_valid),
		.cmp_stall (cmp_stall),
		.cmp_word  (cmp_word),
		.dec_valid (dec_valid),
		.dec_stall (dec_stall),
		.dec_word  (dec_word)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void push_result(input logic [7:0] b, input logic st, input logic last,
			input logic fin);
		dec_word_t r;
		r.out_byte   = b;
		r.status     = st;
		r.run_last   = last;
		r.stream_end = fin;
		dec_expected.push_back(r);
	endfunction

	function automatic void emit_byte(input logic [7:0] b, input logic last);
		hist_mem[wr_ptr] = b;
		wr_ptr = wr_ptr + 12'd1;
		if (made_cnt < WIN_BYTES) made_cnt = made_cnt + 13'd1;
		left_cnt = left_cnt - 24'd1;
		push_result(b, 1'b0, last, left_cnt == 24'd0);
	endfunction

	function automatic void next_token();
		if (tok_idx == 3'd7) begin
			tok_idx   = 3'd0;
			cur_phase = ST_FLAGS;
		end else begin
			tok_idx   = tok_idx + 3'd1;
			cur_phase = ST_TOKEN;
		end
		if (left_cnt == 24'd0) cur_phase = ST_IDLE;
	endfunction

	function automatic void decode_word(input cmp_word_t w);
		logic [4:0]  len;
		logic [12:0] mdist;
		logic [11:0] rd_ptr;
		logic [7:0]  v;
		int          cnt;
		if (w.stream_start) begin
			if (w.in_byte != TYPE_BYTE) begin
				cur_phase = ST_IDLE;
				push_result(8'h00, 1'b1, 1'b1, 1'b0);
			end else begin
				cur_phase = ST_SIZE_LO;
				left_cnt  = '0;
				made_cnt  = '0;
				wr_ptr    = '0;
				flag_reg  = '0;
				tok_idx   = '0;
				match_hi  = '0;
			end
		end else begin
			case (cur_phase)
				ST_SIZE_LO: begin
					left_cnt[7:0] = w.in_byte;
					cur_phase     = ST_SIZE_MID;
				end
				ST_SIZE_MID: begin
					left_cnt[15:8] = w.in_byte;
					cur_phase      = ST_SIZE_HI;
				end
				ST_SIZE_HI: begin
					left_cnt[23:16] = w.in_byte;
					cur_phase       = (left_cnt == 24'd0) ? ST_IDLE : ST_FLAGS;
				end
				ST_FLAGS: begin
					flag_reg  = w.in_byte;
					tok_idx   = 3'd0;
					cur_phase = ST_TOKEN;
				end
				ST_TOKEN: begin
					if (flag_reg[3'd7 - tok_idx]) begin
						match_hi  = w.in_byte;
						cur_phase = ST_MATCH_LO;
					end else begin
						emit_byte(w.in_byte, 1'b1);
						next_token();
					end
				end
				ST_MATCH_LO: begin
					len   = {1'b0, match_hi[7:4]} + MATCH_MIN;
					mdist = {1'b0, match_hi[3:0], w.in_byte} + 13'd1;
					cnt   = (len < left_cnt) ? int'(len) : int'(left_cnt);
					for (int i = 0; i < cnt; i++) begin
						// reads before the stream start give zero
						rd_ptr = wr_ptr - mdist[11:0];
						v = (mdist <= made_cnt) ? hist_mem[rd_ptr] : 8'h00;
						emit_byte(v, i == cnt - 1);
					end
					next_token();
				end
				default: cur_phase = ST_IDLE;
			endcase
		end
	endfunction

	// prediction on input words, then checking of output words
	always @(posedge clk) begin
		dec_word_t want;
		if (arst_n) begin
			if (cmp_valid && !cmp_stall) begin
				in_words++;
				if (cmp_word.stream_start || cur_phase != ST_IDLE) useful_words++;
				decode_word(cmp_word);
			end
			if (dec_valid && !dec_stall) begin
				out_words++;
				if (dec_expected.size() == 0) begin
					$display("%0t: unexpected word, expected none, got %h", $time, dec_word);
					fail_count++;
				end else begin
					want = dec_expected.pop_front();
					if (dec_word.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %h got %h", $time,
							want.out_byte, dec_word.out_byte);
						fail_count++;
					end
					if (dec_word.status !== want.status) begin
						$display("%0t: status expected %b got %b", $time,
							want.status, dec_word.status);
						fail_count++;
					end
					if (dec_word.run_last !== want.run_last) begin
						$display("%0t: run_last expected %b got %b", $time,
							want.run_last, dec_word.run_last);
						fail_count++;
					end
					if (dec_word.stream_end !== want.stream_end) begin
						$display("%0t: stream_end expected %b got %b", $time,
							want.stream_end, dec_word.stream_end);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmp_valid && !cmp_stall) || (dec_valid && !dec_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// output side
	initial begin
		int n;
		dec_stall = 1'b0;
		forever begin
			if (hold_done != hold_req) begin
				repeat (LONG_HOLD) begin
					@(negedge clk);
					dec_stall <= 1'b1;
				end
				hold_done++;
			end
			n = rx_eager ? 0 : $urandom_range(0, 11);
			repeat (n) begin
				@(negedge clk);
				dec_stall <= 1'b1;
			end
			@(negedge clk);
			dec_stall <= 1'b0;
			@(posedge clk);
			while (!dec_valid) @(posedge clk);
		end
	end

	task automatic send_word(input logic [7:0] b, input logic start);
		cmp_word_t w;
		int        gap;
		w.in_byte      = b;
		w.stream_start = start;
		gap = tx_eager ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			@(negedge clk);
			cmp_valid <= 1'b0;
		end
		@(negedge clk);
		cmp_valid <= 1'b1;
		cmp_word  <= w;
		@(posedge clk);
		while (cmp_stall) @(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		cmp_valid <= 1'b0;
		while (dec_expected.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// well-formed stream with random tokens; cut_at > 0 abandons it at the next flag byte once that many words are sent
	task automatic send_stream(input int size, input int match_pct, input int cut_at);
		logic [7:0]  flags;
		logic [3:0]  len;
		logic [11:0] dm1;
		int          made;
		int          sent;
		int          span;
		int          k;
		stream_count++;
		send_word(TYPE_BYTE, 1'b1);
		send_word(size[7:0], 1'b0);
		send_word(size[15:8], 1'b0);
		send_word(size[23:16], 1'b0);
		sent = 4;
		made = 0;
		while (made < size && (cut_at == 0 || sent < cut_at)) begin
			for (k = 0; k < 8; k++) flags[k] = ($urandom_range(0, 99) < match_pct);
			send_word(flags, 1'b0);
			sent++;
			k = 7;
			while (k >= 0 && made < size) begin
				if (flags[k]) begin
					len  = 4'($urandom_range(0, 15));
					span = (made < WIN_BYTES) ? made : WIN_BYTES;
					if (span > 0 && $urandom_range(0, 7) != 0)
						dm1 = 12'($urandom_range(1, span) - 1);
					else
						dm1 = 12'($urandom_range(0, WIN_BYTES - 1));
					send_word({len, dm1[11:8]}, 1'b0);
					send_word(dm1[7:0], 1'b0);
					made += int'(len) + 3;
					sent += 2;
				end else begin
					send_word(8'($urandom_range(0, 255)), 1'b0);
					made++;
					sent++;
				end
				k--;
			end
		end
	endtask

	task automatic test_header_errors();
		send_word(8'hff, 1'b1);
		send_word(8'h00, 1'b1);
		drain();
	endtask

	// literal, match reaching before the start, run-length match cut at the size
	task automatic test_tokens();
		send_word(TYPE_BYTE, 1'b1);
		send_word(8'h0c, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h50, 1'b0);
		send_word(8'ha5, 1'b0);
		send_word(8'h2f, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(8'h5a, 1'b0);
		send_word(8'hf0, 1'b0);
		send_word(8'h00, 1'b0);
		drain();
	endtask

	// longest match, restart into a zero-size stream, then an ignored idle byte
	task automatic test_restart();
		send_word(TYPE_BYTE, 1'b1);
		send_word(8'hff, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(8'hff, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hf0, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(TYPE_BYTE, 1'b1);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hff, 1'b0);
		drain();
	endtask

	task automatic test_full_rate();
		tx_eager = 1'b1;
		rx_eager = 1'b1;
		send_stream(60, 50, 0);
		drain();
		tx_eager = 1'b0;
		rx_eager = 1'b0;
	endtask

	task automatic test_backpressure();
		hold_req++;
		send_stream(120, 60, 0);
		drain();
	endtask

	task automatic test_random_traffic();
		int target;
		int r;
		target = useful_words + RANDOM_WORDS;
		while (useful_words < target) begin
			tx_eager = ($urandom_range(0, 9) == 0);
			rx_eager = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 60)
				send_stream($urandom_range(1, 40), $urandom_range(0, 60), 0);
			else if (r < 72)
				send_stream($urandom_range(41, 200), 30, 0);
			else if (r < 84)
				send_stream(int'($urandom() & 32'h00ffffff), 40, $urandom_range(4, 20));
			else if (r < 92)
				send_word(8'($urandom_range(0, 255)), 1'b0);
			else
				send_word(8'($urandom_range(0, 255)), 1'b1);
		end
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cmp_valid = 1'b0;
		cmp_word  = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_header_errors();
		test_tokens();
		test_restart();
		test_full_rate();
		test_backpressure();
		test_random_traffic();

		if (dec_expected.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, dec_expected.size());
			fail_count++;
		end
		$display("run covered %0d streams, %0d input words and %0d output words",
			stream_count, in_words, out_words);
		$display("with random gaps, full-rate stretches and one long output hold");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
